@@ hdl/priority_schedule_time_calc_defines.svh @@
// assertion macros for the rtl file priority_schedule_time_calc.sv
`ifndef PRIORITY_SCHEDULE_TIME_CALC_DEFINES_SVH
`define PRIORITY_SCHEDULE_TIME_CALC_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/psched_pkg.sv @@
package psched_pkg;

    // field widths of the input and result beats
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int ID_OUT_W = 5;
    localparam int TIME_W   = 20;
    localparam int TOT_W    = 24;

endpackage

@@ hdl/psched_ram.sv @@
module psched_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rd_data_reg <= ram_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

@@ hdl/priority_schedule_time_calc.sv @@
// nonpreemptive priority scheduler, all processes arriving at time zero
// input channel (in_valid / in_stall): one beat loads one process (burst,
// priority); processes are numbered from 1 in arrival order, beats beyond
// MAX_PROCS are dropped but their last_item mark still starts scheduling
// loading writes each beat that fits into the table; the beat with last_item set starts an
// exchange sort on ascending priority, then the emit pass
// sort: one table memory with a single read and write port and one compare
// unit; each outer step a runs FETCH_A, FETCH_B, one CMP per later entry, then WB
// emit: one result beat per process on the output channel
// (out_valid / out_stall); each beat is formed in S_EM_CALC and held in S_EM_OUT
// until out_stall is low, and the next beat is formed only then; last_result marks
// the final beat
// in_stall is high from the last_item beat until the final result beat is
// taken; a stalled result beat holds its payload and the block waits
// reset clears the process count and the sequencer; table contents are
// left as they are and only loaded entries are ever read
`include "priority_schedule_time_calc_defines.svh"

module priority_schedule_time_calc #(
    parameter int MAX_PROCS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [psched_pkg::BURST_W-1:0]   burst_time,
    input  logic [psched_pkg::PRIO_W-1:0]    prio_value,
    input  logic                             last_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [psched_pkg::ID_OUT_W-1:0]  proc_id,
    output logic [psched_pkg::BURST_W-1:0]   burst_out,
    output logic [psched_pkg::PRIO_W-1:0]    prio_out,
    output logic [psched_pkg::TIME_W-1:0]    turnaround,
    output logic [psched_pkg::TIME_W-1:0]    waiting,
    output logic [psched_pkg::TOT_W-1:0]     total_turnaround,
    output logic [psched_pkg::TOT_W-1:0]     total_waiting,
    output logic                             last_result
);

    import psched_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int ENT_W = CNT_W + BURST_W + PRIO_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH_A,
        S_FETCH_B,
        S_CMP,
        S_WB,
        S_EM_RD,
        S_EM_CALC,
        S_EM_OUT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   a_reg;
    logic [IDX_W-1:0]   b_reg;
    logic [ENT_W-1:0]   cur_reg;
    logic [TOT_W-1:0]   done_reg;
    logic [TOT_W-1:0]   tot_tat_reg;
    logic [TOT_W-1:0]   tot_wt_reg;

    logic                out_valid_reg;
    logic [ID_OUT_W-1:0] proc_id_reg;
    logic [BURST_W-1:0]  burst_out_reg;
    logic [PRIO_W-1:0]   prio_out_reg;
    logic [TIME_W-1:0]   turnaround_reg;
    logic [TIME_W-1:0]   waiting_reg;
    logic                last_result_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;

    logic               in_fire;
    logic               tbl_full;
    logic [CNT_W-1:0]   load_cnt;
    logic [CNT_W-1:0]   new_id;
    logic [CNT_W-1:0]   ent_id;
    logic [BURST_W-1:0] ent_burst;
    logic [PRIO_W-1:0]  ent_prio;
    logic [PRIO_W-1:0]  cur_prio;
    logic               do_swap;
    logic               b_at_end;
    logic               a_more;
    logic               a_at_end;
    logic [TOT_W-1:0]   done_new;

    // process table memory
    psched_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry fields and compare unit
    assign ent_prio  = ram_rdata[PRIO_W-1:0];
    assign ent_burst = ram_rdata[PRIO_W +: BURST_W];
    assign ent_id    = ram_rdata[PRIO_W + BURST_W +: CNT_W];
    assign cur_prio  = cur_reg[PRIO_W-1:0];
    assign do_swap   = cur_prio > ent_prio;

    // load side
    assign in_stall = (state_reg != S_LOAD);
    assign in_fire  = in_valid && !in_stall;
    assign tbl_full = (count_reg >= CNT_W'(MAX_PROCS));
    assign new_id   = count_reg + CNT_W'(1);
    assign load_cnt = tbl_full ? count_reg : new_id;

    // loop bounds
    assign b_at_end = (CNT_W'(b_reg) + CNT_W'(1)) == count_reg;
    assign a_more   = (CNT_W'(a_reg) + CNT_W'(2)) < count_reg;
    assign a_at_end = (CNT_W'(a_reg) + CNT_W'(1)) == count_reg;

    // running completion time
    assign done_new = done_reg + TOT_W'(ent_burst);

    // table port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = a_reg;
        ram_wdata = cur_reg;
        ram_raddr = a_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                ram_we    = in_fire && !tbl_full;
                ram_waddr = count_reg[IDX_W-1:0];
                ram_wdata = {new_id, burst_time, prio_value};
            end
            S_FETCH_A:
            begin
                ram_raddr = a_reg;
            end
            S_FETCH_B:
            begin
                ram_raddr = b_reg;
            end
            S_CMP:
            begin
                ram_we    = do_swap;
                ram_waddr = b_reg;
                ram_raddr = b_reg + IDX_W'(1);
            end
            S_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = a_reg;
            end
            S_EM_RD:
            begin
                ram_raddr = a_reg;
            end
            S_EM_CALC:
            begin
                ram_raddr = a_reg;
            end
            S_EM_OUT:
            begin
                ram_raddr = a_reg + IDX_W'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer, datapath and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            count_reg       <= '0;
            a_reg           <= '0;
            b_reg           <= '0;
            cur_reg         <= '0;
            done_reg        <= '0;
            tot_tat_reg     <= '0;
            tot_wt_reg      <= '0;
            out_valid_reg   <= 1'b0;
            proc_id_reg     <= '0;
            burst_out_reg   <= '0;
            prio_out_reg    <= '0;
            turnaround_reg  <= '0;
            waiting_reg     <= '0;
            last_result_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        count_reg <= load_cnt;
                        if (last_item)
                        begin
                            a_reg       <= '0;
                            b_reg       <= IDX_W'(1);
                            done_reg    <= '0;
                            tot_tat_reg <= '0;
                            tot_wt_reg  <= '0;
                            if (load_cnt >= CNT_W'(2))
                            begin
                                state_reg <= S_FETCH_A;
                            end
                            else
                            begin
                                state_reg <= S_EM_RD;
                            end
                        end
                    end
                end
                S_FETCH_A:
                begin
                    state_reg <= S_FETCH_B;
                end
                S_FETCH_B:
                begin
                    cur_reg   <= ram_rdata;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (do_swap)
                    begin
                        cur_reg <= ram_rdata;
                    end
                    if (b_at_end)
                    begin
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        b_reg <= b_reg + IDX_W'(1);
                    end
                end
                S_WB:
                begin
                    if (a_more)
                    begin
                        a_reg     <= a_reg + IDX_W'(1);
                        b_reg     <= a_reg + IDX_W'(2);
                        state_reg <= S_FETCH_A;
                    end
                    else
                    begin
                        a_reg     <= '0;
                        state_reg <= S_EM_RD;
                    end
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_CALC;
                end
                S_EM_CALC:
                begin
                    proc_id_reg     <= ID_OUT_W'(ent_id);
                    burst_out_reg   <= ent_burst;
                    prio_out_reg    <= ent_prio;
                    turnaround_reg  <= done_new[TIME_W-1:0];
                    waiting_reg     <= done_reg[TIME_W-1:0];
                    tot_tat_reg     <= tot_tat_reg + done_new;
                    tot_wt_reg      <= tot_wt_reg + done_reg;
                    done_reg        <= done_new;
                    last_result_reg <= a_at_end;
                    out_valid_reg   <= 1'b1;
                    state_reg       <= S_EM_OUT;
                end
                S_EM_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_result_reg)
                        begin
                            count_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            a_reg     <= a_reg + IDX_W'(1);
                            state_reg <= S_EM_CALC;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // result ports
    assign out_valid        = out_valid_reg;
    assign proc_id          = proc_id_reg;
    assign burst_out        = burst_out_reg;
    assign prio_out         = prio_out_reg;
    assign turnaround       = turnaround_reg;
    assign waiting          = waiting_reg;
    assign total_turnaround = tot_tat_reg;
    assign total_waiting    = tot_wt_reg;
    assign last_result      = last_result_reg;

    // no load beat is taken while a result beat is pending
    `PSC_ASSERT_NOW(a_no_load_while_out, clk, rst_n, !in_stall, !out_valid)

    // table count never exceeds its capacity
    `PSC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_PROCS))

    // inner sort index always runs ahead of the outer one
    `PSC_ASSERT_NOW(a_sort_order, clk, rst_n, state_reg == S_CMP, a_reg < b_reg)

    // waiting plus burst gives turnaround on every result beat
    `PSC_ASSERT_NOW(a_wait_sum, clk, rst_n, out_valid,
        TIME_W'(waiting + TIME_W'(burst_out)) == turnaround)

    // final result beat taken returns the block to loading with an empty table
    `PSC_ASSERT_NEXT(a_end_of_set, clk, rst_n, out_valid && !out_stall && last_result,
        !in_stall && (count_reg == '0))

endmodule

@@ tb/sv/priority_schedule_time_calc_tb.sv @@
`timescale 1ns / 100ps

module priority_schedule_time_calc_tb;

    import psched_pkg::*;

    localparam int TB_MAX_PROCS = 16;
    localparam int DRAIN_CYCLES = 60;

    // one loaded process table entry
    typedef struct {
        logic [ID_OUT_W-1:0] id;
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
    } proc_entry_t;

    // one expected schedule beat
    typedef struct {
        logic [ID_OUT_W-1:0] id;
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
        logic [TIME_W-1:0]   tat;
        logic [TIME_W-1:0]   wt;
        logic [TOT_W-1:0]    tot_tat;
        logic [TOT_W-1:0]    tot_wt;
        logic                is_last;
    } sched_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [BURST_W-1:0]  burst_time;
    logic [PRIO_W-1:0]   prio_value;
    logic                last_item;
    logic                out_valid;
    logic                out_stall;
    logic [ID_OUT_W-1:0] proc_id;
    logic [BURST_W-1:0]  burst_out;
    logic [PRIO_W-1:0]   prio_out;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic [TOT_W-1:0]    total_turnaround;
    logic [TOT_W-1:0]    total_waiting;
    logic                last_result;

    proc_entry_t   loaded_procs[$];
    sched_result_t sched_results[$];
    int            error_count = 0;
    int            items_sent = 0;
    bit            tx_idle_on = 1'b0;
    bit            rx_idle_on = 1'b0;
    int            rx_hold_cycles = 0;

    priority_schedule_time_calc #(
        .MAX_PROCS(TB_MAX_PROCS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .burst_time(burst_time),
        .prio_value(prio_value),
        .last_item(last_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .proc_id(proc_id),
        .burst_out(burst_out),
        .prio_out(prio_out),
        .turnaround(turnaround),
        .waiting(waiting),
        .total_turnaround(total_turnaround),
        .total_waiting(total_waiting),
        .last_result(last_result)
    );

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // load one process; on the closing beat sort by priority and queue the schedule
    function automatic void schedule_beat(input logic [BURST_W-1:0] burst,
                                          input logic [PRIO_W-1:0] prio,
                                          input logic is_last);
        proc_entry_t   entry;
        proc_entry_t   order[$];
        proc_entry_t   swap_tmp;
        sched_result_t res;
        logic [31:0]   done_ticks;
        logic [31:0]   wait_ticks;
        logic [31:0]   sum_tat;
        logic [31:0]   sum_wt;
        int            n;
        // table full: beat is dropped, its closing mark still counts
        if (loaded_procs.size() < TB_MAX_PROCS)
        begin
            entry.id    = ID_OUT_W'(loaded_procs.size() + 1);
            entry.burst = burst;
            entry.prio  = prio;
            loaded_procs.push_back(entry);
        end
        if (!is_last)
            return;
        order = loaded_procs;
        n = order.size();
        // exchange sort, ascending priority value
        for (int a = 0; a + 1 < n; a++)
        begin
            for (int b = a + 1; b < n; b++)
            begin
                if (order[a].prio > order[b].prio)
                begin
                    swap_tmp = order[a];
                    order[a] = order[b];
                    order[b] = swap_tmp;
                end
            end
        end
        // running completion time and totals
        done_ticks = 0;
        sum_tat = 0;
        sum_wt = 0;
        for (int k = 0; k < n; k++)
        begin
            done_ticks  = done_ticks + order[k].burst;
            wait_ticks  = done_ticks - order[k].burst;
            sum_tat     = sum_tat + done_ticks;
            sum_wt      = sum_wt + wait_ticks;
            res.id      = order[k].id;
            res.burst   = order[k].burst;
            res.prio    = order[k].prio;
            res.tat     = done_ticks[TIME_W-1:0];
            res.wt      = wait_ticks[TIME_W-1:0];
            res.tot_tat = sum_tat[TOT_W-1:0];
            res.tot_wt  = sum_wt[TOT_W-1:0];
            res.is_last = (k + 1 == n);
            sched_results.push_back(res);
        end
        loaded_procs.delete();
    endfunction

    task automatic check_field(input string field, input int unsigned got,
                               input int unsigned want, input int unsigned id);
        if (got != want)
            report_mismatch($sformatf("proc %0d %s got %0d want %0d", id, field, got, want));
    endtask

    // compare every accepted result beat with the oldest expected one
    always @(posedge clk)
    begin : result_check
        sched_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sched_results.size() == 0)
                report_mismatch($sformatf("result beat for proc %0d with none pending", proc_id));
            else
            begin
                exp_res = sched_results.pop_front();
                check_field("proc_id", proc_id, exp_res.id, exp_res.id);
                check_field("burst_out", burst_out, exp_res.burst, exp_res.id);
                check_field("prio_out", prio_out, exp_res.prio, exp_res.id);
                check_field("turnaround", turnaround, exp_res.tat, exp_res.id);
                check_field("waiting", waiting, exp_res.wt, exp_res.id);
                check_field("total_turnaround", total_turnaround, exp_res.tot_tat, exp_res.id);
                check_field("total_waiting", total_waiting, exp_res.tot_wt, exp_res.id);
                check_field("last_result", last_result, exp_res.is_last, exp_res.id);
            end
        end
    end

    // result side stall: long hold-off first, then random bursts
    initial
    begin : result_stall
        int burst_left;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                rx_hold_cycles--;
            end
            else if (rx_idle_on && burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                burst_left = $urandom_range(1, 18) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // offer one beat from a falling edge, wait for it to be taken, maybe go idle
    task automatic send_process(input logic [BURST_W-1:0] burst,
                                input logic [PRIO_W-1:0] prio,
                                input logic is_last);
        int gap;
        in_valid   <= 1'b1;
        burst_time <= burst;
        prio_value <= prio;
        last_item  <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        schedule_beat(burst, prio, is_last);
        items_sent++;
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic sender_idle();
        in_valid <= 1'b0;
    endtask

    // sender pause until the schedule has fully come out
    task automatic wait_results_drained();
        sender_idle();
        while (sched_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one set with random content; sizes past the table exercise dropping
    task automatic send_random_set(input int n_procs);
        int prio_mode;
        int burst_mode;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        prio_mode  = $urandom_range(0, 2);
        burst_mode = $urandom_range(0, 2);
        for (int k = 0; k < n_procs; k++)
        begin
            case (burst_mode)
                0: burst = BURST_W'($urandom_range(0, 65535));
                1: burst = BURST_W'($urandom_range(0, 15));
                default: burst = ($urandom_range(0, 1) == 1) ? 16'hFFFF :
                                 BURST_W'($urandom_range(0, 65535));
            endcase
            case (prio_mode)
                0: prio = PRIO_W'($urandom_range(0, 255));
                1: prio = PRIO_W'($urandom_range(0, 3));
                default: prio = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            endcase
            send_process(burst, prio, k == n_procs - 1);
        end
    endtask

    function automatic int random_set_size();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(TB_MAX_PROCS + 1, TB_MAX_PROCS + 4);
        return $urandom_range(1, TB_MAX_PROCS);
    endfunction

    // one-process sets at both ends of the field ranges
    task automatic test_single_extremes();
        send_process(16'hFFFF, 8'hFF, 1'b1);
        send_process(16'h0000, 8'h00, 1'b1);
        wait_results_drained();
    endtask

    // equal priorities keep the order the exchange sort leaves
    task automatic test_priority_ties();
        send_process(16'd10, 8'd5, 1'b0);
        send_process(16'd20, 8'd3, 1'b0);
        send_process(16'd30, 8'd5, 1'b0);
        send_process(16'd40, 8'd3, 1'b1);
        wait_results_drained();
    endtask

    // full table of maximum bursts in reverse priority, then a dropped closing beat
    task automatic test_table_full();
        for (int k = 0; k < TB_MAX_PROCS; k++)
            send_process(16'hFFFF, 8'(255 - 16 * k), 1'b0);
        send_process(16'h1234, 8'h00, 1'b1);
        wait_results_drained();
    endtask

    // random sets with idling on both sides
    task automatic test_random_traffic(input int item_target);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        while (items_sent < item_target)
            send_random_set(random_set_size());
        wait_results_drained();
    endtask

    // receiver holds off while the sender keeps offering sets
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        for (int s = 0; s < 3; s++)
            send_random_set($urandom_range(6, TB_MAX_PROCS));
        wait_results_drained();
        send_random_set($urandom_range(2, TB_MAX_PROCS));
        wait_results_drained();
    endtask

    // back to back with no idling at all
    task automatic test_full_rate(input int item_target);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (items_sent < item_target)
            send_random_set(random_set_size());
        wait_results_drained();
    endtask

    initial
    begin
        in_valid   = 1'b0;
        burst_time = '0;
        prio_value = '0;
        last_item  = 1'b0;
        out_stall  = 1'b0;
        rst_n      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_extremes();
        test_priority_ties();
        test_table_full();
        test_random_traffic(260);
        test_backpressure();
        test_full_rate(350);

        // let any stray beat show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[priority_schedule_time_calc] OK");
        else
            $display("[priority_schedule_time_calc] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("[priority_schedule_time_calc] ERROR");
        $finish;
    end

endmodule
